/* rtl/core/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants for the button debounce block
// Configuration register indexes, reset values and the bundles passed
// between the configuration registers, the press state machine and the top.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned DbcW   = 8;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegOpenLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDbcTarget  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongTarget = 2'd2;

  // Reset values of the registers
  localparam logic             OpenLevelRst  = 1'b1;
  localparam logic [DbcW-1:0]  DbcTargetRst  = 8'd5;
  localparam logic [HoldW-1:0] LongTargetRst = 16'd100;

  // Event kinds
  localparam logic EvtShort = 1'b0;
  localparam logic EvtLong  = 1'b1;

  typedef struct packed {
    logic             open_level;
    logic [DbcW-1:0]  dbc_target;
    logic [HoldW-1:0] long_target;
  } bdlp_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [HoldW-1:0] count;
  } bdlp_evt_t;

endpackage

/* rtl/core/bdlp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bdlp_cfg_regs: configuration registers
// Holds the open level, the debounce target and the long-press target.
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bdlp_pkg::bdlp_cfg_t           cfg_o
);
  import bdlp_pkg::*;

  bdlp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_level  <= OpenLevelRst;
      cfg_q.dbc_target  <= DbcTargetRst;
      cfg_q.long_target <= LongTargetRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOpenLevel:  cfg_q.open_level  <= cfg_wdata_i[0];
        RegDbcTarget:  cfg_q.dbc_target  <= cfg_wdata_i[DbcW-1:0];
        RegLongTarget: cfg_q.long_target <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bdlp_fsm.sv */
// ----------------------------------------------------------------------------
// bdlp_fsm: press state machine
// Open, closed-short and closed-long modes with saturating counters; one
// sample is processed per step and at most one event is produced.
// ----------------------------------------------------------------------------
module bdlp_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdlp_pkg::bdlp_cfg_t cfg_i,
  input  logic                step_i,
  input  logic                pin_level_i,
  output bdlp_pkg::bdlp_evt_t evt_o
);
  import bdlp_pkg::*;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_LONG  = 2'd2
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [DbcW-1:0]  dbc_q, dbc_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [HoldW-1:0] long_q, long_d;

  logic             released;
  logic [DbcW-1:0]  dbc_inc;
  logic [HoldW-1:0] hold_inc;
  logic [HoldW-1:0] long_inc;
  logic             dbc_done;
  bdlp_evt_t        evt;

  assign released = (pin_level_i == cfg_i.open_level);
  assign dbc_inc  = (&dbc_q)  ? dbc_q  : dbc_q + 1'b1;
  assign hold_inc = (&hold_q) ? hold_q : hold_q + 1'b1;
  assign long_inc = (&long_q) ? long_q : long_q + 1'b1;
  assign dbc_done = (dbc_inc >= cfg_i.dbc_target);

  always_comb begin
    mode_d    = mode_q;
    dbc_d     = dbc_q;
    hold_d    = hold_q;
    long_d    = long_q;
    evt.valid = 1'b0;
    evt.kind  = EvtShort;
    evt.count = '0;
    case (mode_q)
      MODE_SHORT: begin
        if (released && dbc_done) begin
          mode_d    = MODE_OPEN;
          dbc_d     = '0;
          hold_d    = '0;
          evt.valid = 1'b1;
        end else begin
          dbc_d = released ? dbc_inc : '0;
          if (hold_inc >= cfg_i.long_target) begin
            mode_d    = MODE_LONG;
            dbc_d     = '0;
            hold_d    = '0;
            long_d    = {{(HoldW-1){1'b0}}, 1'b1};
            evt.valid = 1'b1;
            evt.kind  = EvtLong;
            evt.count = {{(HoldW-1){1'b0}}, 1'b1};
          end else begin
            hold_d = hold_inc;
          end
        end
      end
      MODE_LONG: begin
        evt.valid = 1'b1;
        evt.kind  = EvtLong;
        if (released && dbc_done) begin
          mode_d = MODE_OPEN;
          dbc_d  = '0;
          hold_d = '0;
        end else begin
          dbc_d     = released ? dbc_inc : '0;
          long_d    = long_inc;
          evt.count = long_inc;
        end
      end
      default: begin
        // open, and the unused code which behaves as open
        mode_d = MODE_OPEN;
        if (!released) begin
          if (dbc_done) begin
            mode_d = MODE_SHORT;
            dbc_d  = '0;
          end else begin
            dbc_d = dbc_inc;
          end
        end else begin
          dbc_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OPEN;
      dbc_q  <= '0;
      hold_q <= '0;
      long_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      dbc_q  <= dbc_d;
      hold_q <= hold_d;
      long_q <= long_d;
    end
  end

  assign evt_o = evt;

  // Hold counter only runs in closed-short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_SHORT) |-> (hold_q == '0))
    else $error("hold counter nonzero outside closed-short");

  // Short-press events never carry a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt.valid && (evt.kind == EvtShort)) |-> (evt.count == '0))
    else $error("short event with nonzero count");

  // Entering closed-long starts the long count at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_q == MODE_SHORT) && (mode_d == MODE_LONG))
      |=> (long_q == {{(HoldW-1){1'b0}}, 1'b1}))
    else $error("long count not started at one");

  // Long mode emits on every step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_LONG) |-> (evt.valid && (evt.kind == EvtLong)))
    else $error("closed-long step without long event");

endmodule

/* rtl/core/button_debounce_long_press_unit.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit: button debouncer with long-press repeat
// Each input transfer is one poll tick carrying the sampled pin level. A
// press is accepted after debounce_target consecutive closed samples; a
// release from closed-short gives a short event (kind 0, count 0). Holding
// for long_press_target ticks gives a long event with count 1, then one long
// event per tick with a rising count saturating at 65535; a release from
// closed-long gives a long event with count 0. Rate: one sample per clock
// while no stalled event holds the output register. A sample is captured
// in the input register; the state machine processes it on a step and
// loads its event (if any) into the output register at the end of that
// cycle. The input side stalls only while the output register holds an
// event that the receiver stalls.
// ----------------------------------------------------------------------------
module button_debounce_long_press_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          pin_level_i,
  // event channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          event_kind_o,
  output logic [bdlp_pkg::HoldW-1:0]    hold_count_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bdlp_pkg::*;

  bdlp_cfg_t cfg;
  bdlp_evt_t evt;

  logic             smp_valid_q;
  logic             smp_pin_q;
  logic             step;
  logic             out_valid_q;
  logic             out_kind_q;
  logic [HoldW-1:0] out_count_q;

  // Advance the state machine when a sample waits and the output register
  // is empty or drains this cycle.
  assign step       = smp_valid_q && (!out_valid_q || !out_stall_i);
  // Take a new sample whenever the held one moves on (or there is none).
  assign in_stall_o = smp_valid_q && !step;

  bdlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdlp_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .pin_level_i (smp_pin_q),
    .evt_o       (evt)
  );

  // Input register: hold the sample until the state machine consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      smp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      smp_pin_q <= pin_level_i;
    end
  end

  // Output register: load an event on a step, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= evt.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && evt.valid) begin
      out_kind_q  <= evt.kind;
      out_count_q <= evt.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign hold_count_o = out_count_q;

endmodule

/* dv/bdlp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdlp_checker: event predictor and scoreboard for the button debouncer
// Watches the sample, event and configuration ports of the debouncer, keeps
// its own copy of the press state and of the registers, works out the event
// each accepted sample gives, and compares every event transfer with the
// oldest one still due. Hands the mismatch count and the number of events
// still due back to the testbench top.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          pin_level_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          event_kind_i,
  input  logic [bdlp_pkg::HoldW-1:0]    hold_count_i,
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import bdlp_pkg::*;

  typedef enum logic [1:0] {
    PressOpen  = 2'd0,
    PressShort = 2'd1,
    PressLong  = 2'd2
  } press_mode_e;

  typedef struct packed {
    logic             kind;
    logic [HoldW-1:0] count;
  } press_event_t;

  bdlp_cfg_t        cfg_q;
  press_mode_e      mode_q;
  logic [DbcW-1:0]  dbc_q;
  logic [HoldW-1:0] held_q;
  logic [HoldW-1:0] long_q;
  press_event_t     events_due[$];
  int               mismatches;

  task automatic push_event(input logic kind, input logic [HoldW-1:0] count);
    press_event_t ev;
    ev.kind  = kind;
    ev.count = count;
    events_due.push_back(ev);
  endtask

  // Advance the press state by one poll tick and queue the event it gives.
  task automatic predict_tick(input logic level);
    logic released;
    released = (level == cfg_q.open_level);
    if (mode_q == PressShort || mode_q == PressLong) begin
      if (released) begin
        if (dbc_q != '1) dbc_q++;
        if (dbc_q >= cfg_q.dbc_target) begin
          push_event((mode_q == PressLong) ? EvtLong : EvtShort, '0);
          mode_q = PressOpen;
          dbc_q  = '0;
          held_q = '0;
          return;
        end
      end else begin
        dbc_q = '0;
      end
      if (mode_q == PressShort) begin
        // a pending release does not hold back the long press
        if (held_q != '1) held_q++;
        if (held_q >= cfg_q.long_target) begin
          mode_q = PressLong;
          dbc_q  = '0;
          held_q = '0;
          long_q = 16'd1;
          push_event(EvtLong, 16'd1);
        end
      end else begin
        if (long_q != '1) long_q++;
        push_event(EvtLong, long_q);
      end
    end else begin
      mode_q = PressOpen;
      if (!released) begin
        if (dbc_q != '1) dbc_q++;
        if (dbc_q >= cfg_q.dbc_target) begin
          mode_q = PressShort;
          dbc_q  = '0;
        end
      end else begin
        dbc_q = '0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    press_event_t want;
    if (!rst_ni) begin
      cfg_q.open_level  = OpenLevelRst;
      cfg_q.dbc_target  = DbcTargetRst;
      cfg_q.long_target = LongTargetRst;
      mode_q            = PressOpen;
      dbc_q             = '0;
      held_q            = '0;
      long_q            = '0;
      mismatches        = 0;
      events_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare first: an event never leaves in the cycle its sample arrives
      if (out_valid_i && !out_stall_i) begin
        if (events_due.size() == 0) begin
          $display("%0t: event with none due: expected none, actual kind %0d count %0d",
                   $time, event_kind_i, hold_count_i);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          if (want.kind !== event_kind_i) begin
            $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, event_kind_i);
            mismatches++;
          end
          if (want.count !== hold_count_i) begin
            $display("%0t: hold_count mismatch: expected %0d, actual %0d",
                     $time, want.count, hold_count_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegOpenLevel:  cfg_q.open_level  = cfg_wdata_i[0];
          RegDbcTarget:  cfg_q.dbc_target  = cfg_wdata_i[DbcW-1:0];
          RegLongTarget: cfg_q.long_target = cfg_wdata_i[HoldW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_tick(pin_level_i);
      fail_count_o <= mismatches;
      pending_o    <= events_due.size();
    end
  end

endmodule

/* dv/tb_button_debounce_long_press_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_unit: testbench for the button debouncer
// Drives poll-tick samples and register writes into the debouncer, stalls
// the event side at random, and leaves prediction and comparison to the
// checker beside it. A directed part covers the default setting, zero
// targets, releases pending in both closed modes, large targets and a long
// event-side stall; a random part follows with press sequences, bounces and
// noise under changing settings.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_unit;
  import bdlp_pkg::*;

  localparam int RandomItems   = 220;
  localparam int WatchdogLimit = 3000;  // longest quiet stretch is the long hold
  localparam int RxHoldCycles  = 300;
  localparam int DrainCycles   = 6;     // room for a sample still in the input and output registers

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                pin_level   = 1'b0;
  logic                out_stall   = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = RegOpenLevel;
  logic [CfgDataW-1:0] cfg_wdata   = '0;

  logic                in_stall;
  logic                out_valid;
  logic                event_kind;
  logic [HoldW-1:0]    hold_count;

  int                  fail_count;
  int                  pending;

  // Knobs for the sample driver and the event-side staller
  bit                  tx_idle_en  = 1'b1;
  bit                  rx_idle_en  = 1'b1;
  bit                  rx_hold_req = 1'b0;

  // Our view of the current register setting, used to shape sequences
  logic                cur_open    = OpenLevelRst;
  int                  cur_dbc     = DbcTargetRst;
  int                  cur_long    = LongTargetRst;
  int                  ticks_sent  = 0;
  int                  idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  button_debounce_long_press_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pin_level_i  (pin_level),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_o (event_kind),
    .hold_count_o (hold_count),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  bdlp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pin_level_i  (pin_level),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_i (event_kind),
    .hold_count_i (hold_count),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Event-side staller: every pass drives one stall value and holds it for a
  // number of cycles, so the stall gets at most one update per clock edge.
  // A hold request from the stimulus turns into one long stretch of stall.
  initial begin
    logic stall_val;
    int   stall_len;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_val   = 1'b1;
        stall_len   = RxHoldCycles;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_val = 1'b1;
        stall_len = $urandom_range(1, 17);
      end else begin
        stall_val = 1'b0;
        stall_len = $urandom_range(1, 24);
      end
      out_stall <= stall_val;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("button_debounce_long_press_unit verification failed");
        $finish;
      end
    end
  end

  // Offer one sample, maybe after a random gap, and hold it until the
  // transfer. Valid stays high afterwards so back-to-back samples need no
  // second update of valid in the same step.
  task automatic send_tick(input logic lvl);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    do @(posedge clk_i); while (in_stall);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Drop valid and wait until every event due has arrived, then let the
  // pipeline empty out, since a sample can leave no event behind.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic lvl_open, input int dbc, input int lng);
    write_reg(RegOpenLevel, CfgDataW'(lvl_open));
    write_reg(RegDbcTarget, CfgDataW'(dbc));
    write_reg(RegLongTarget, CfgDataW'(lng));
    cur_open = lvl_open;
    cur_dbc  = dbc;
    cur_long = lng;
  endtask

  initial begin
    int rand_base;
    int run_len;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setting: press through debounce, release before long press.
    hold_level(1'b0, 8);
    hold_level(1'b1, 8);
    settle();

    // Zero targets: every step is accepted on its first qualifying tick.
    // Press goes straight to long, then a press released in closed-short.
    apply_config(1'b0, 0, 0);
    hold_level(1'b1, 4);
    hold_level(1'b0, 1);
    settle();
    apply_config(1'b0, 0, 1);
    hold_level(1'b1, 1);
    hold_level(1'b0, 1);
    settle();

    // Release pending in closed-short lets the long press start first,
    // then a release pending in closed-long keeps the updates coming.
    apply_config(1'b1, 3, 6);
    hold_level(1'b0, 7);
    hold_level(1'b1, 3);
    hold_level(1'b0, 1);
    hold_level(1'b1, 3);
    settle();

    // Largest debounce target with a quick long press, then the largest
    // long-press target with a short press released well before it.
    tx_idle_en = 1'b0;
    apply_config(1'b0, 255, 3);
    hold_level(1'b1, 255 + 6);
    hold_level(1'b0, 255);
    settle();
    apply_config(1'b1, 1, 65535);
    hold_level(1'b0, 12);
    hold_level(1'b1, 2);
    settle();

    // Stall the event side for a long stretch while samples keep coming
    // so the block backs up onto its input.
    apply_config(1'b1, 0, 1);
    rx_hold_req = 1'b1;
    hold_level(1'b0, 120);
    hold_level(1'b1, 1);
    settle();
    tx_idle_en = 1'b1;

    // Random part: mostly well-formed presses with random lengths under
    // small random settings, some bounces, short releases and plain noise.
    rand_base = ticks_sent;
    while (ticks_sent - rand_base < RandomItems) begin
      if (ticks_sent - rand_base > RandomItems * 3 / 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      settle();
      apply_config(1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10));
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 4) != 0) begin
          repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)));
          hold_level(~cur_open, cur_dbc + $urandom_range(0, cur_long + 8));
          // now and then cut the release short to leave it pending
          run_len = cur_dbc + $urandom_range(0, 3);
          if ($urandom_range(0, 5) == 0) run_len = run_len - $urandom_range(1, 3);
          hold_level(cur_open, run_len);
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("button_debounce_long_press_unit verification clean");
    end else begin
      $display("button_debounce_long_press_unit verification failed");
    end
    $finish;
  end

endmodule

/* button_debounce_long_press_unit.f */
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_cfg_regs.sv
rtl/core/bdlp_fsm.sv
rtl/core/button_debounce_long_press_unit.sv
dv/bdlp_checker.sv
dv/tb_button_debounce_long_press_unit.sv
